@@ hw/rtl/baro_temp_pressure_compensation_core_assert.svh @@
// assertion macros for the compensation core
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_CORE_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_CORE_ASSERT_SVH

// same-cycle implication
`define BTPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/btpc_pkg.sv @@
// shared types, constants and helpers of the compensation core
package btpc_pkg;

  localparam int RAW_W     = 20;
  localparam int VALUE_W   = 40;
  localparam int DATA_W    = 64;
  localparam int FINE_W    = 32;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] FINE_OFFSET = 64'd128000;
  localparam logic [DATA_W-1:0] PRESS_FULL  = 64'd1048576;
  localparam logic [DATA_W-1:0] NUM_SCALE   = 64'd3125;
  localparam logic [DATA_W-1:0] ROUND_T     = 64'd128;
  localparam logic [DATA_W-1:0] P1_BIAS     = 64'h0000_8000_0000_0000;

  localparam logic [CNT_W-1:0] NB_CAL   = 7'd16;
  localparam logic [CNT_W-1:0] NB_D2    = 7'd18;
  localparam logic [CNT_W-1:0] NB_A     = 7'd34;
  localparam logic [CNT_W-1:0] NB_P1    = 7'd17;
  localparam logic [CNT_W-1:0] NB_SCALE = 7'd13;
  localparam logic [CNT_W-1:0] NB_X     = 7'd51;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_CALIB,
    REG_PRESS_A,
    REG_PRESS_B,
    REG_PRESS_LAST
  } cfg_reg_t;

  typedef enum logic {
    OP_TEMP,
    OP_PRESS
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_DIFF,
    ST_T_V1,
    ST_T_SQ,
    ST_T_V2,
    ST_T_FINE,
    ST_T_OUT,
    ST_P_A,
    ST_P_AA,
    ST_P_B6,
    ST_P_B5,
    ST_P_B4,
    ST_P_AA3,
    ST_P_A3,
    ST_P_A2,
    ST_P_P1,
    ST_P_CHK,
    ST_P_N3125,
    ST_P_DIV,
    ST_P_X9,
    ST_P_XX,
    ST_P_B8,
    ST_P_SUM1,
    ST_P_SUM2,
    ST_P_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  nbits;
    logic [DATA_W-1:0] mcand;
    logic [DATA_W-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
  } div_rsp_t;

  function automatic logic [DATA_W-1:0] sx16(input logic [15:0] x);
    return {{(DATA_W-16){x[15]}}, x};
  endfunction

  function automatic logic [DATA_W-1:0] sx32(input logic [31:0] x);
    return {{(DATA_W-32){x[31]}}, x};
  endfunction

  function automatic logic [DATA_W-1:0] asr(input logic [DATA_W-1:0] v,
                                            input logic [5:0] s);
    return DATA_W'($signed(v) >>> s);
  endfunction

endpackage

@@ hw/rtl/btpc_in_if.sv @@
// input channel interface
interface btpc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [btpc_pkg::RAW_W-1:0]    raw_sample;

  modport source (output valid, output operation, output raw_sample, input ready);
  modport sink   (input valid, input operation, input raw_sample, output ready);
endinterface

@@ hw/rtl/btpc_out_if.sv @@
// result channel interface
interface btpc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic signed [btpc_pkg::VALUE_W-1:0]  value;
  logic                                 divide_by_zero;

  modport source (output valid, output kind, output value, output divide_by_zero,
                  input ready);
  modport sink   (input valid, input kind, input value, input divide_by_zero,
                  output ready);
endinterface

@@ hw/rtl/btpc_mul.sv @@
// bit-serial signed multiplier, product modulo 2^64
module btpc_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  btpc_pkg::mul_req_t req,
  output btpc_pkg::mul_rsp_t rsp
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [btpc_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [btpc_pkg::DATA_W-1:0]     acc_r, acc_nxt;
  logic [btpc_pkg::DATA_W-1:0]     mc_r, mc_nxt;
  logic [btpc_pkg::DATA_W-1:0]     mp_r, mp_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.nbits;
      acc_nxt  = '0;
      mc_nxt   = req.mcand;
      mp_nxt   = req.mplier;
    end else if (busy_r) begin
      // top multiplier bit carries negative weight
      if (mp_r[0]) begin
        acc_nxt = (cnt_r == btpc_pkg::CNT_W'(1)) ? acc_r - mc_r : acc_r + mc_r;
      end
      mc_nxt  = mc_r << 1;
      mp_nxt  = mp_r >> 1;
      cnt_nxt = cnt_r - btpc_pkg::CNT_W'(1);
      if (cnt_r == btpc_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

@@ hw/rtl/btpc_div.sv @@
// restoring signed divider, one quotient bit per cycle, truncates toward zero
module btpc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  btpc_pkg::div_req_t req,
  output btpc_pkg::div_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic                          neg_r, neg_nxt;
  logic [btpc_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [btpc_pkg::DATA_W-1:0]   rem_r, rem_nxt;
  logic [btpc_pkg::DATA_W-1:0]   quo_r, quo_nxt;
  logic [btpc_pkg::DATA_W-1:0]   den_r, den_nxt;
  logic [btpc_pkg::DATA_W:0]     rem_sh;
  logic [btpc_pkg::DATA_W:0]     rem_sub;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_sh   = {rem_r, quo_r[btpc_pkg::DATA_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = btpc_pkg::CNT_W'(btpc_pkg::DATA_W);
      neg_nxt  = req.num[btpc_pkg::DATA_W-1] ^ req.den[btpc_pkg::DATA_W-1];
      rem_nxt  = '0;
      quo_nxt  = req.num[btpc_pkg::DATA_W-1] ? -req.num : req.num;
      den_nxt  = req.den[btpc_pkg::DATA_W-1] ? -req.den : req.den;
    end else if (busy_r) begin
      if (!rem_sub[btpc_pkg::DATA_W]) begin
        rem_nxt = rem_sub[btpc_pkg::DATA_W-1:0];
        quo_nxt = {quo_r[btpc_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[btpc_pkg::DATA_W-1:0];
        quo_nxt = {quo_r[btpc_pkg::DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - btpc_pkg::CNT_W'(1);
      if (cnt_r == btpc_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? -quo_r : quo_r;

endmodule

@@ hw/rtl/baro_temp_pressure_compensation_core.sv @@
// Barometric temperature/pressure compensation core. One item in flight at a
// time: the work of an item is paced by the bit-serial multiplier (one
// multiplier bit per cycle, 13 to 51 bits per product) and the restoring
// divider. The input is taken again as soon as the sequencer is idle, while
// a finished result may still wait in the output register. Temperature
// results are in 0.01 degC, pressure results in Pa as Q24.8; a zero pressure
// divisor gives 0 with the divide_by_zero flag. Calibration words are to be
// written on the cfg port only while the core is idle; the core itself does
// not enforce this.
`include "baro_temp_pressure_compensation_core_assert.svh"

module baro_temp_pressure_compensation_core (
  input  logic                              clk,
  input  logic                              rst_n,
  btpc_in_if.sink                           in_chan,
  btpc_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [btpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [btpc_pkg::DATA_W-1:0]       cfg_wdata
);

  localparam int DW = btpc_pkg::DATA_W;
  localparam int VW = btpc_pkg::VALUE_W;

  btpc_pkg::state_t             state_r, state_nxt;
  logic                         issued_r, issued_nxt;
  logic [47:0]                  temp_calib_r;
  logic [DW-1:0]                press_a_r;
  logic [DW-1:0]                press_b_r;
  logic [15:0]                  press_last_r;
  logic [btpc_pkg::FINE_W-1:0]  ft_r, ft_nxt;
  logic [btpc_pkg::RAW_W-1:0]   raw_r, raw_nxt;
  logic [DW-1:0]                ra_r, ra_nxt;
  logic [DW-1:0]                rb_r, rb_nxt;
  logic [DW-1:0]                rc_r, rc_nxt;
  logic [DW-1:0]                rd_r, rd_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_kind_r, out_kind_nxt;
  logic [VW-1:0]                out_value_r, out_value_nxt;
  logic                         out_dz_r, out_dz_nxt;

  btpc_pkg::mul_req_t           mreq;
  btpc_pkg::mul_rsp_t           mrsp;
  btpc_pkg::div_req_t           dreq;
  btpc_pkg::div_rsp_t           drsp;

  logic [DW-1:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic          slot_free;
  logic          use_mul, use_div;
  logic [DW-1:0] tmp;

  assign t1 = {{(DW-16){1'b0}}, temp_calib_r[15:0]};
  assign t2 = btpc_pkg::sx16(temp_calib_r[31:16]);
  assign t3 = btpc_pkg::sx16(temp_calib_r[47:32]);
  assign p1 = {{(DW-16){1'b0}}, press_a_r[15:0]};
  assign p2 = btpc_pkg::sx16(press_a_r[31:16]);
  assign p3 = btpc_pkg::sx16(press_a_r[47:32]);
  assign p4 = btpc_pkg::sx16(press_a_r[63:48]);
  assign p5 = btpc_pkg::sx16(press_b_r[15:0]);
  assign p6 = btpc_pkg::sx16(press_b_r[31:16]);
  assign p7 = btpc_pkg::sx16(press_b_r[47:32]);
  assign p8 = btpc_pkg::sx16(press_b_r[63:48]);
  assign p9 = btpc_pkg::sx16(press_last_r);

  assign slot_free = !out_valid_r || out_chan.ready;

  btpc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  btpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    state_nxt     = state_r;
    ft_nxt        = ft_r;
    raw_nxt       = raw_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    rc_nxt        = rc_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_dz_nxt    = out_dz_r;
    mreq          = '0;
    dreq          = '0;
    use_mul       = 1'b0;
    use_div       = 1'b0;
    tmp           = '0;

    unique case (state_r)
      btpc_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          raw_nxt   = in_chan.raw_sample;
          state_nxt = (in_chan.operation == btpc_pkg::OP_PRESS) ?
                      btpc_pkg::ST_P_A : btpc_pkg::ST_T_DIFF;
        end
      end
      btpc_pkg::ST_T_DIFF: begin
        ra_nxt    = {{(DW-17){1'b0}}, raw_r[19:3]} - (t1 << 1);
        rb_nxt    = {{(DW-16){1'b0}}, raw_r[19:4]} - t1;
        state_nxt = btpc_pkg::ST_T_V1;
      end
      btpc_pkg::ST_T_V1: begin
        use_mul = 1'b1;
        mreq.mcand = ra_r; mreq.mplier = t2; mreq.nbits = btpc_pkg::NB_CAL;
        if (mrsp.done) begin
          ra_nxt    = btpc_pkg::asr(mrsp.prod, 6'd11);
          state_nxt = btpc_pkg::ST_T_SQ;
        end
      end
      btpc_pkg::ST_T_SQ: begin
        use_mul = 1'b1;
        mreq.mcand = rb_r; mreq.mplier = rb_r; mreq.nbits = btpc_pkg::NB_D2;
        if (mrsp.done) begin
          rb_nxt    = btpc_pkg::asr(mrsp.prod, 6'd12);
          state_nxt = btpc_pkg::ST_T_V2;
        end
      end
      btpc_pkg::ST_T_V2: begin
        use_mul = 1'b1;
        mreq.mcand = rb_r; mreq.mplier = t3; mreq.nbits = btpc_pkg::NB_CAL;
        if (mrsp.done) begin
          rb_nxt    = btpc_pkg::asr(mrsp.prod, 6'd14);
          state_nxt = btpc_pkg::ST_T_FINE;
        end
      end
      btpc_pkg::ST_T_FINE: begin
        tmp       = ra_r + rb_r;
        ft_nxt    = tmp[31:0];
        ra_nxt    = btpc_pkg::sx32(tmp[31:0]);
        state_nxt = btpc_pkg::ST_T_OUT;
      end
      btpc_pkg::ST_T_OUT: begin
        if (slot_free) begin
          tmp           = btpc_pkg::asr((ra_r << 2) + ra_r + btpc_pkg::ROUND_T, 6'd8);
          out_valid_nxt = 1'b1;
          out_kind_nxt  = btpc_pkg::OP_TEMP;
          out_value_nxt = tmp[VW-1:0];
          out_dz_nxt    = 1'b0;
          state_nxt     = btpc_pkg::ST_IDLE;
        end
      end
      btpc_pkg::ST_P_A: begin
        ra_nxt    = btpc_pkg::sx32(ft_r) - btpc_pkg::FINE_OFFSET;
        state_nxt = btpc_pkg::ST_P_AA;
      end
      btpc_pkg::ST_P_AA: begin
        use_mul = 1'b1;
        mreq.mcand = ra_r; mreq.mplier = ra_r; mreq.nbits = btpc_pkg::NB_A;
        if (mrsp.done) begin
          rb_nxt    = mrsp.prod;
          state_nxt = btpc_pkg::ST_P_B6;
        end
      end
      btpc_pkg::ST_P_B6: begin
        use_mul = 1'b1;
        mreq.mcand = rb_r; mreq.mplier = p6; mreq.nbits = btpc_pkg::NB_CAL;
        if (mrsp.done) begin
          rb_nxt    = mrsp.prod;
          state_nxt = btpc_pkg::ST_P_B5;
        end
      end
      btpc_pkg::ST_P_B5: begin
        use_mul = 1'b1;
        mreq.mcand = ra_r; mreq.mplier = p5; mreq.nbits = btpc_pkg::NB_CAL;
        if (mrsp.done) begin
          rb_nxt    = rb_r + (mrsp.prod << 17);
          state_nxt = btpc_pkg::ST_P_B4;
        end
      end
      btpc_pkg::ST_P_B4: begin
        rb_nxt    = rb_r + (p4 << 35);
        state_nxt = btpc_pkg::ST_P_AA3;
      end
      btpc_pkg::ST_P_AA3: begin
        use_mul = 1'b1;
        mreq.mcand = ra_r; mreq.mplier = ra_r; mreq.nbits = btpc_pkg::NB_A;
        if (mrsp.done) begin
          rc_nxt    = mrsp.prod;
          state_nxt = btpc_pkg::ST_P_A3;
        end
      end
      btpc_pkg::ST_P_A3: begin
        use_mul = 1'b1;
        mreq.mcand = rc_r; mreq.mplier = p3; mreq.nbits = btpc_pkg::NB_CAL;
        if (mrsp.done) begin
          rc_nxt    = btpc_pkg::asr(mrsp.prod, 6'd8);
          state_nxt = btpc_pkg::ST_P_A2;
        end
      end
      btpc_pkg::ST_P_A2: begin
        use_mul = 1'b1;
        mreq.mcand = ra_r; mreq.mplier = p2; mreq.nbits = btpc_pkg::NB_CAL;
        if (mrsp.done) begin
          ra_nxt    = rc_r + (mrsp.prod << 12);
          state_nxt = btpc_pkg::ST_P_P1;
        end
      end
      btpc_pkg::ST_P_P1: begin
        use_mul = 1'b1;
        mreq.mcand  = ra_r + btpc_pkg::P1_BIAS;
        mreq.mplier = p1;
        mreq.nbits  = btpc_pkg::NB_P1;
        if (mrsp.done) begin
          ra_nxt    = btpc_pkg::asr(mrsp.prod, 6'd33);
          state_nxt = btpc_pkg::ST_P_CHK;
        end
      end
      btpc_pkg::ST_P_CHK: begin
        if (ra_r == '0) begin
          // zero divisor: flagged result
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = btpc_pkg::OP_PRESS;
            out_value_nxt = '0;
            out_dz_nxt    = 1'b1;
            state_nxt     = btpc_pkg::ST_IDLE;
          end
        end else begin
          tmp       = btpc_pkg::PRESS_FULL - {{(DW-btpc_pkg::RAW_W){1'b0}}, raw_r};
          rc_nxt    = (tmp << 31) - rb_r;
          state_nxt = btpc_pkg::ST_P_N3125;
        end
      end
      btpc_pkg::ST_P_N3125: begin
        use_mul = 1'b1;
        mreq.mcand  = rc_r;
        mreq.mplier = btpc_pkg::NUM_SCALE;
        mreq.nbits  = btpc_pkg::NB_SCALE;
        if (mrsp.done) begin
          rc_nxt    = mrsp.prod;
          state_nxt = btpc_pkg::ST_P_DIV;
        end
      end
      btpc_pkg::ST_P_DIV: begin
        use_div  = 1'b1;
        dreq.num = rc_r;
        dreq.den = ra_r;
        if (drsp.done) begin
          rc_nxt    = drsp.quo;
          state_nxt = btpc_pkg::ST_P_X9;
        end
      end
      btpc_pkg::ST_P_X9: begin
        use_mul = 1'b1;
        mreq.mcand  = btpc_pkg::asr(rc_r, 6'd13);
        mreq.mplier = p9;
        mreq.nbits  = btpc_pkg::NB_CAL;
        if (mrsp.done) begin
          rd_nxt    = mrsp.prod;
          state_nxt = btpc_pkg::ST_P_XX;
        end
      end
      btpc_pkg::ST_P_XX: begin
        use_mul = 1'b1;
        mreq.mcand  = rd_r;
        mreq.mplier = btpc_pkg::asr(rc_r, 6'd13);
        mreq.nbits  = btpc_pkg::NB_X;
        if (mrsp.done) begin
          ra_nxt    = btpc_pkg::asr(mrsp.prod, 6'd25);
          state_nxt = btpc_pkg::ST_P_B8;
        end
      end
      btpc_pkg::ST_P_B8: begin
        use_mul = 1'b1;
        mreq.mcand = rc_r; mreq.mplier = p8; mreq.nbits = btpc_pkg::NB_CAL;
        if (mrsp.done) begin
          rb_nxt    = btpc_pkg::asr(mrsp.prod, 6'd19);
          state_nxt = btpc_pkg::ST_P_SUM1;
        end
      end
      btpc_pkg::ST_P_SUM1: begin
        rc_nxt    = rc_r + ra_r + rb_r;
        state_nxt = btpc_pkg::ST_P_SUM2;
      end
      btpc_pkg::ST_P_SUM2: begin
        rd_nxt    = btpc_pkg::asr(rc_r, 6'd8) + (p7 << 4);
        state_nxt = btpc_pkg::ST_P_OUT;
      end
      btpc_pkg::ST_P_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = btpc_pkg::OP_PRESS;
          out_dz_nxt    = 1'b0;
          // saturate to the result width
          if (rd_r[DW-1:VW-1] == {(DW-VW+1){rd_r[DW-1]}}) begin
            out_value_nxt = rd_r[VW-1:0];
          end else begin
            out_value_nxt = rd_r[DW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
          end
          state_nxt = btpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = btpc_pkg::ST_IDLE;
      end
    endcase

    mreq.start = use_mul && !issued_r;
    dreq.start = use_div && !issued_r;
    issued_nxt = issued_r;
    if (mreq.start || dreq.start) begin
      issued_nxt = 1'b1;
    end
    if (mrsp.done || drsp.done) begin
      issued_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= btpc_pkg::ST_IDLE;
      issued_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      ft_r         <= '0;
      temp_calib_r <= '0;
      press_a_r    <= '0;
      press_b_r    <= '0;
      press_last_r <= '0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      ft_r        <= ft_nxt;
      if (cfg_we) begin
        unique case (btpc_pkg::cfg_reg_t'(cfg_index))
          btpc_pkg::REG_TEMP_CALIB: temp_calib_r <= cfg_wdata[47:0];
          btpc_pkg::REG_PRESS_A:    press_a_r    <= cfg_wdata;
          btpc_pkg::REG_PRESS_B:    press_b_r    <= cfg_wdata;
          btpc_pkg::REG_PRESS_LAST: press_last_r <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
    end
    raw_r       <= raw_nxt;
    ra_r        <= ra_nxt;
    rb_r        <= rb_nxt;
    rc_r        <= rc_nxt;
    rd_r        <= rd_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_dz_r    <= out_dz_nxt;
  end

  assign in_chan.ready           = (state_r == btpc_pkg::ST_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.kind           = out_kind_r;
  assign out_chan.value          = out_value_r;
  assign out_chan.divide_by_zero = out_dz_r;

  `BTPC_ASSERT_NEXT(a_accept_starts_work, in_chan.valid && in_chan.ready,
    state_r != btpc_pkg::ST_IDLE, "accepted transaction did not start the sequencer")
  `BTPC_ASSERT_NOW(a_dz_only_pressure, out_valid_r && out_dz_r,
    out_kind_r == btpc_pkg::OP_PRESS && out_value_r == '0, "bad divide-by-zero result")
  `BTPC_ASSERT_NOW(a_fine_only_from_temp, ft_r != $past(ft_r),
    $past(state_r) == btpc_pkg::ST_T_FINE, "fine temperature changed outside its step")

endmodule
